/* rtl/lcsr_pkg.sv */
// ============================================================================
// lcsr_pkg
// Shared types and constants for the load-cell converter serial reader.
// ============================================================================
`default_nettype none

package lcsr_pkg;

    localparam int DATA_BITS  = 24;
    localparam int TICK_W     = $clog2(2 * (DATA_BITS + 3));
    localparam int PULSE_W    = TICK_W - 1;
    localparam int VALUE_W    = 24;
    localparam int TOP_W      = 16;
    localparam int TOP_LSB    = 8;
    localparam int EXT_W      = 32;

    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_A128 = 2'd1,
        SRC_B32  = 2'd2,
        SRC_A64  = 2'd3
    } t_source;

    typedef struct packed {
        logic               clock_line;
        logic               busy_res;
        logic               ready_res;
        logic               value_valid;
        logic [VALUE_W-1:0] sample_value;
        logic [TOP_W-1:0]   sample_top16;
    } t_result;

    // data pulses plus gain-select pulses
    function automatic logic [TICK_W-1:0] pulse_total(input t_source src);
        logic [TICK_W-1:0] total;
        unique case (src)
            SRC_B32:  total = TICK_W'(DATA_BITS + 2);
            SRC_A64:  total = TICK_W'(DATA_BITS + 3);
            default:  total = TICK_W'(DATA_BITS + 1);
        endcase
        return total;
    endfunction

endpackage

`default_nettype wire

/* rtl/lcsr_core.sv */
// ============================================================================
// lcsr_core
// Read sequencer state and per-tick result logic; state advances on each beat.
// ============================================================================
`default_nettype none

module lcsr_core
    import lcsr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire logic    i_data_line,
    input  wire logic    i_start_read,
    input  wire logic [1:0] i_asked_source,
    input  wire logic [1:0] i_next_source,
    output t_result      o_result
);

    logic                 r_active;
    logic [TICK_W-1:0]    r_tick;
    logic [DATA_BITS-1:0] r_shift;
    t_source              r_armed;
    t_source              r_pending;

    logic                 n_active;
    logic [TICK_W-1:0]    n_tick;
    logic [DATA_BITS-1:0] n_shift;
    t_source              n_armed;
    t_source              n_pending;

    logic [PULSE_W-1:0]   pulse;
    logic                 last_pulse;
    logic signed [EXT_W-1:0] ext;

    assign pulse      = r_tick[TICK_W-1:1];
    assign last_pulse = ({1'b0, pulse} + TICK_W'(1)) >= pulse_total(r_pending);
    assign ext        = EXT_W'(signed'(r_shift));

    always_comb begin
        n_active  = r_active;
        n_tick    = r_tick;
        n_shift   = r_shift;
        n_armed   = r_armed;
        n_pending = r_pending;
        o_result  = '0;
        if (!r_active) begin
            o_result.ready_res = !i_data_line &&
                (t_source'(i_asked_source) == r_armed || r_armed == SRC_NONE);
            if (i_start_read) begin
                n_active  = 1'b1;
                n_tick    = '0;
                n_shift   = '0;
                n_pending = t_source'(i_next_source);
            end
        end else if (!r_tick[0]) begin
            o_result.clock_line = 1'b1;
            if (pulse < PULSE_W'(DATA_BITS)) begin
                n_shift = {r_shift[DATA_BITS-2:0], i_data_line};
            end
            n_tick = r_tick + TICK_W'(1);
        end else if (last_pulse) begin
            o_result.value_valid  = 1'b1;
            o_result.sample_value = ext[VALUE_W-1:0];
            o_result.sample_top16 = ext[TOP_LSB+TOP_W-1:TOP_LSB];
            n_armed  = r_pending;
            n_active = 1'b0;
            n_tick   = '0;
        end else begin
            n_tick = r_tick + TICK_W'(1);
        end
        o_result.busy_res = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_tick    <= '0;
            r_shift   <= '0;
            r_armed   <= SRC_NONE;
            r_pending <= SRC_NONE;
        end else if (i_step) begin
            r_active  <= n_active;
            r_tick    <= n_tick;
            r_shift   <= n_shift;
            r_armed   <= n_armed;
            r_pending <= n_pending;
        end
    end

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.value_valid |-> !o_result.busy_res)
        else $error("read completed while still busy");

    a_idle_tick_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> r_tick == '0)
        else $error("tick count nonzero while idle");

    a_high_then_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_active && !r_tick[0] |=> r_active && r_tick[0])
        else $error("high half not followed by low half");

    a_start_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !r_active && i_start_read |=> r_active && r_shift == '0)
        else $error("start did not begin a clean read");

endmodule

`default_nettype wire

/* rtl/lcsr_out_reg.sv */
// ============================================================================
// lcsr_out_reg
// Result register between the sequencer and the output channel.
// ============================================================================
`default_nettype none

module lcsr_out_reg
    import lcsr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_stall,
    output logic         o_valid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

/* rtl/load_cell_adc_serial_reader.sv */
// ============================================================================
// load_cell_adc_serial_reader
// Serial master for a 24-bit load-cell converter, one half-period tick a beat.
// ============================================================================
//  channel | valid       | stall        | payload
//  in      | i_in_valid  | o_in_stall   | data_line, start_read, asked/next source
//  out     | o_out_valid | i_out_stall  | clock_line, busy, ready, value, top16
//
//  One beat in, one beat out; an input beat is taken every cycle unless the
//  result register is full and stalled. Results appear in the cycle after the
//  input beat. A read spans 2 * (24 + 1..3) + 1 input beats.
//  Reset clears the sequencer (idle, none armed) and the output valid.
// ============================================================================
`default_nettype none

module load_cell_adc_serial_reader
    import lcsr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_data_line,
    input  wire logic               i_start_read,
    input  wire logic [1:0]         i_asked_source,
    input  wire logic [1:0]         i_next_source,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_clock_line,
    output logic                    o_busy_res,
    output logic                    o_ready_res,
    output logic                    o_value_valid,
    output logic signed [VALUE_W-1:0] o_sample_value,
    output logic signed [TOP_W-1:0]   o_sample_top16
);

    logic    step;
    t_result core_res;
    t_result out_res;

    assign o_in_stall = o_out_valid && i_out_stall;
    assign step       = i_in_valid && !o_in_stall;

    lcsr_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_data_line    (i_data_line),
        .i_start_read   (i_start_read),
        .i_asked_source (i_asked_source),
        .i_next_source  (i_next_source),
        .o_result       (core_res)
    );

    lcsr_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (core_res),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_result (out_res)
    );

    assign o_clock_line   = out_res.clock_line;
    assign o_busy_res     = out_res.busy_res;
    assign o_ready_res    = out_res.ready_res;
    assign o_value_valid  = out_res.value_valid;
    assign o_sample_value = signed'(out_res.sample_value);
    assign o_sample_top16 = signed'(out_res.sample_top16);

endmodule

`default_nettype wire

/* tb/sv/tb_load_cell_adc_serial_reader.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_load_cell_adc_serial_reader
// Self-checking bench for the load-cell converter serial reader. A short
// stimulus table covers idle readiness, a start without ready and starts
// while busy. Random full read sequences follow, covering all sources and
// extreme words. Every output beat is checked field by field against a
// tick-accurate predictor. Both channels are throttled at random.
// ============================================================================

module tb_load_cell_adc_serial_reader;
    import lcsr_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 6;
    localparam int RAND_BEATS  = 1350;
    localparam int PAUSE_READ  = 8;
    localparam int DRAIN_CYC   = 8;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic    data_line;
        logic    start_read;
        t_source asked;
        t_source nxt;
        bit      typed;
        t_result res;
    } t_row;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_in_valid     = 1'b0;
    logic                      i_data_line    = 1'b0;
    logic                      i_start_read   = 1'b0;
    logic [1:0]                i_asked_source = 2'd0;
    logic [1:0]                i_next_source  = 2'd0;
    logic                      i_out_stall    = 1'b0;
    logic                      o_in_stall;
    logic                      o_out_valid;
    logic                      o_clock_line;
    logic                      o_busy_res;
    logic                      o_ready_res;
    logic                      o_value_valid;
    logic signed [VALUE_W-1:0] o_sample_value;
    logic signed [TOP_W-1:0]   o_sample_top16;

    // predictor state
    logic [TICK_W-1:0]    pred_tick    = '0;
    logic [DATA_BITS-1:0] pred_word    = '0;
    t_source              pred_armed   = SRC_NONE;
    t_source              pred_pending = SRC_NONE;
    logic                 pred_active  = 1'b0;

    t_result tick_results_q[$];
    t_row    stim_table[$];

    int err_cnt      = 0;
    int beats_in     = 0;
    int beats_out    = 0;
    int ready_beats  = 0;
    int burst_left   = 0;
    int cycle_cnt    = 0;
    int stall_left   = 0;
    int stall_mode   = 0;
    int reads_by_src[4];

    load_cell_adc_serial_reader u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_line    (i_data_line),
        .i_start_read   (i_start_read),
        .i_asked_source (i_asked_source),
        .i_next_source  (i_next_source),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_clock_line   (o_clock_line),
        .o_busy_res     (o_busy_res),
        .o_ready_res    (o_ready_res),
        .o_value_valid  (o_value_valid),
        .o_sample_value (o_sample_value),
        .o_sample_top16 (o_sample_top16)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats in, %0d out",
                     cycle_cnt, beats_in, beats_out);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR out beat %0d: %s", beats_out, msg);
        err_cnt++;
    endtask

    task automatic predict_tick(input logic dl, input logic st, input t_source asked,
                                input t_source nxt, output t_result res);
        int               pulse;
        int               total;
        logic [EXT_W-1:0] ext;
        res = '0;
        if (!pred_active) begin
            res.ready_res = (dl == 1'b0) && (asked == pred_armed || pred_armed == SRC_NONE);
            if (st) begin
                pred_active  = 1'b1;
                pred_tick    = '0;
                pred_word    = '0;
                pred_pending = nxt;
            end
        end else begin
            pulse = int'(pred_tick >> 1);
            case (pred_pending)
                SRC_B32: total = DATA_BITS + 2;
                SRC_A64: total = DATA_BITS + 3;
                default: total = DATA_BITS + 1;
            endcase
            if (!pred_tick[0]) begin
                res.clock_line = 1'b1;
                if (pulse < DATA_BITS)
                    pred_word = {pred_word[DATA_BITS-2:0], dl};
                pred_tick = pred_tick + 1'b1;
            end else if (pulse + 1 >= total) begin
                ext              = EXT_W'($signed(pred_word));
                res.value_valid  = 1'b1;
                res.sample_value = ext[VALUE_W-1:0];
                res.sample_top16 = ext[TOP_LSB +: TOP_W];
                reads_by_src[pred_pending]++;
                pred_armed  = pred_pending;
                pred_active = 1'b0;
                pred_tick   = '0;
            end else begin
                pred_tick = pred_tick + 1'b1;
            end
        end
        res.busy_res = pred_active;
    endtask

    // one input beat; typed rows carry a hand-written expectation
    task automatic send_beat(input logic dl, input logic st, input t_source asked,
                             input t_source nxt, input bit typed, input t_result typed_res);
        int      gap;
        t_result res;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 30);
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_data_line    <= dl;
        i_start_read   <= st;
        i_asked_source <= asked;
        i_next_source  <= nxt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_tick(dl, st, asked, nxt, res);
        if (typed)
            res = typed_res;
        if (res.ready_res)
            ready_beats++;
        tick_results_q.push_back(res);
        beats_in++;
    endtask

    task automatic add_row(input logic dl, input logic st, input t_source asked,
                           input t_source nxt, input bit typed, input logic clk,
                           input logic busy, input logic ready);
        t_row row;
        row.data_line  = dl;
        row.start_read = st;
        row.asked      = asked;
        row.nxt        = nxt;
        row.typed      = typed;
        row.res        = '0;
        row.res.clock_line = clk;
        row.res.busy_res   = busy;
        row.res.ready_res  = ready;
        stim_table.push_back(row);
    endtask

    // output checker
    always @(posedge i_clk) begin
        t_result got;
        t_result exp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_clock_line, o_busy_res, o_ready_res, o_value_valid,
                   o_sample_value, o_sample_top16};
            if (tick_results_q.size() == 0) begin
                report_mismatch("output beat with nothing expected");
            end else begin
                exp = tick_results_q.pop_front();
                if (got.clock_line !== exp.clock_line)
                    report_mismatch($sformatf("clock_line %b exp %b",
                                              got.clock_line, exp.clock_line));
                if (got.busy_res !== exp.busy_res)
                    report_mismatch($sformatf("busy_res %b exp %b",
                                              got.busy_res, exp.busy_res));
                if (got.ready_res !== exp.ready_res)
                    report_mismatch($sformatf("ready_res %b exp %b",
                                              got.ready_res, exp.ready_res));
                if (got.value_valid !== exp.value_valid)
                    report_mismatch($sformatf("value_valid %b exp %b",
                                              got.value_valid, exp.value_valid));
                if (got.sample_value !== exp.sample_value)
                    report_mismatch($sformatf("sample_value %h exp %h",
                                              got.sample_value, exp.sample_value));
                if (got.sample_top16 !== exp.sample_top16)
                    report_mismatch($sformatf("sample_top16 %h exp %h",
                                              got.sample_top16, exp.sample_top16));
            end
            beats_out++;
        end
    end

    // receiver stall pattern: modes of random length
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_left = $urandom_range(20, 200);
                stall_mode = $urandom_range(0, 3);
            end
            stall_left--;
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 7) == 0);
                2:       i_out_stall <= ($urandom_range(0, 1) == 0);
                default: i_out_stall <= ($urandom_range(0, 15) < 13);
            endcase
        end
    end

    initial begin
        t_result              none_res;
        logic [DATA_BITS-1:0] cur_word;
        int                   idle_left;
        int                   reads_started;
        int                   pulse;
        int                   mode;
        logic                 dl;
        logic                 st;
        t_source              asked;
        t_source              nxt;

        none_res      = '0;
        idle_left     = 0;
        reads_started = 0;
        cur_word      = DATA_BITS'($urandom);
        for (int s = 0; s < 4; s++)
            reads_by_src[s] = 0;

        // idle readiness with nothing armed, then start without ready
        add_row(1'b0, 1'b0, SRC_NONE, SRC_NONE, 1'b1, 1'b0, 1'b0, 1'b1);
        add_row(1'b0, 1'b0, SRC_A64,  SRC_B32,  1'b1, 1'b0, 1'b0, 1'b1);
        add_row(1'b1, 1'b0, SRC_A128, SRC_A128, 1'b1, 1'b0, 1'b0, 1'b0);
        add_row(1'b1, 1'b1, SRC_B32,  SRC_A64,  1'b1, 1'b0, 1'b1, 1'b0);
        // starts while busy are ignored
        add_row(1'b1, 1'b1, SRC_A128, SRC_NONE, 1'b1, 1'b1, 1'b1, 1'b0);
        add_row(1'b0, 1'b1, SRC_A64,  SRC_A128, 1'b1, 1'b0, 1'b1, 1'b0);
        for (int i = 0; i < 16; i++)
            add_row(i[1], i[2], t_source'(i[1:0]), t_source'(i[3:2]), 1'b0,
                    1'b0, 1'b0, 1'b0);

        repeat (RESET_CYC) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[i])
            send_beat(stim_table[i].data_line, stim_table[i].start_read,
                      stim_table[i].asked, stim_table[i].nxt,
                      stim_table[i].typed, stim_table[i].res);

        // random part: read sequences driven from predictor phase
        while (beats_in < RAND_BEATS || pred_active) begin
            nxt   = t_source'($urandom_range(0, 3));
            asked = t_source'($urandom_range(0, 3));
            if (pred_active) begin
                pulse = int'(pred_tick >> 1);
                if (!pred_tick[0] && pulse < DATA_BITS)
                    dl = cur_word[DATA_BITS-1-pulse];
                else
                    dl = $urandom_range(0, 1);
                st = ($urandom_range(0, 15) == 0);
            end else if (idle_left > 0) begin
                idle_left--;
                dl = ($urandom_range(0, 3) == 0);
                st = 1'b0;
                if ($urandom_range(0, 1) == 0)
                    asked = pred_armed;
            end else begin
                if (reads_started == PAUSE_READ) begin
                    @(negedge i_clk);
                    i_in_valid <= 1'b0;
                    while (tick_results_q.size() != 0) @(posedge i_clk);
                    burst_left = 0;
                end
                mode = $urandom_range(0, 7);
                case (mode)
                    0:       cur_word = '1;
                    1:       cur_word = '0;
                    2:       cur_word = {1'b1, {(DATA_BITS-1){1'b0}}};
                    3:       cur_word = {1'b0, {(DATA_BITS-1){1'b1}}};
                    default: cur_word = DATA_BITS'($urandom);
                endcase
                dl        = $urandom_range(0, 1);
                st        = 1'b1;
                idle_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                        : $urandom_range(0, 6);
                reads_started++;
            end
            send_beat(dl, st, asked, nxt, 1'b0, none_res);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tick_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("Run covered %0d input beats, %0d checked, ready on %0d idle beats.",
                 beats_in, beats_out, ready_beats);
        $display("Reads completed per source: none %0d, A128 %0d, B32 %0d, A64 %0d.",
                 reads_by_src[SRC_NONE], reads_by_src[SRC_A128],
                 reads_by_src[SRC_B32], reads_by_src[SRC_A64]);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/lcsr_pkg.sv
rtl/lcsr_core.sv
rtl/lcsr_out_reg.sv
rtl/load_cell_adc_serial_reader.sv
tb/sv/tb_load_cell_adc_serial_reader.sv
